@@ rtl/line_follow_pid_with_obstacle_stop_assert.svh @@
// assertion helpers for the rtl
`ifndef LINE_FOLLOW_PID_WITH_OBSTACLE_STOP_ASSERT_SVH
`define LINE_FOLLOW_PID_WITH_OBSTACLE_STOP_ASSERT_SVH

// same-cycle implication
`define LFPID_ASSERT_NOW(name, clk, rst, cond, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("lfpid same-cycle check failed");

// next-cycle implication
`define LFPID_ASSERT_NEXT(name, clk, rst, cond, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("lfpid next-cycle check failed");

`endif

@@ rtl/lfpid_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lfpid_pkg;

   localparam int DATA_WIDTH     = 32;
   localparam int GAIN_WIDTH     = 16;
   localparam int RANGE_WIDTH    = 16;
   localparam int MODE_WIDTH     = 2;
   localparam int FRAC_BITS      = 12;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int REG_SEL_LSB    = 2;
   localparam int REG_SEL_WIDTH  = 3;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_RANGE = 2'd0,
      MODE_POSE  = 2'd1,
      MODE_TICK  = 2'd2
   } mode_type;

   typedef enum logic [REG_SEL_WIDTH-1:0] {
      REG_TARGET_LINE     = 3'd0,
      REG_CRUISE_SPEED    = 3'd1,
      REG_PROP_GAIN       = 3'd2,
      REG_INTEGRAL_GAIN   = 3'd3,
      REG_DERIVATIVE_GAIN = 3'd4,
      REG_STOP_RANGE      = 3'd5
   } reg_index_type;

   localparam logic signed [DATA_WIDTH-1:0] TARGET_LINE_RESET  = -32'sd655360;
   localparam logic signed [DATA_WIDTH-1:0] CRUISE_SPEED_RESET = 32'sd65536;
   localparam logic signed [GAIN_WIDTH-1:0] PROP_GAIN_RESET    = 16'sd410;
   localparam logic signed [GAIN_WIDTH-1:0] INT_GAIN_RESET     = 16'sd0;
   localparam logic signed [GAIN_WIDTH-1:0] DER_GAIN_RESET     = 16'sd0;
   localparam logic [RANGE_WIDTH-1:0]       STOP_RANGE_RESET   = 16'd77;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] target_line;
      logic signed [DATA_WIDTH-1:0] cruise_speed;
      logic signed [GAIN_WIDTH-1:0] prop_gain;
      logic signed [GAIN_WIDTH-1:0] integral_gain;
      logic signed [GAIN_WIDTH-1:0] derivative_gain;
      logic [RANGE_WIDTH-1:0]       stop_range;
   } cfg_type;

endpackage

`default_nettype wire

@@ rtl/lfpid_csr.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lfpid_csr import lfpid_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                           csr_pready,
   output cfg_type                        cfg
);

   cfg_type                  cfg_ff;
   cfg_type                  cfg_in;
   logic                     wr_en;
   logic [REG_SEL_WIDTH-1:0] reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[REG_SEL_LSB +: REG_SEL_WIDTH];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_TARGET_LINE: begin
               cfg_in.target_line = csr_pwdata[DATA_WIDTH-1:0];
            end
            REG_CRUISE_SPEED: begin
               cfg_in.cruise_speed = csr_pwdata[DATA_WIDTH-1:0];
            end
            REG_PROP_GAIN: begin
               cfg_in.prop_gain = csr_pwdata[GAIN_WIDTH-1:0];
            end
            REG_INTEGRAL_GAIN: begin
               cfg_in.integral_gain = csr_pwdata[GAIN_WIDTH-1:0];
            end
            REG_DERIVATIVE_GAIN: begin
               cfg_in.derivative_gain = csr_pwdata[GAIN_WIDTH-1:0];
            end
            REG_STOP_RANGE: begin
               cfg_in.stop_range = csr_pwdata[RANGE_WIDTH-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_line     <= TARGET_LINE_RESET;
         cfg_ff.cruise_speed    <= CRUISE_SPEED_RESET;
         cfg_ff.prop_gain       <= PROP_GAIN_RESET;
         cfg_ff.integral_gain   <= INT_GAIN_RESET;
         cfg_ff.derivative_gain <= DER_GAIN_RESET;
         cfg_ff.stop_range      <= STOP_RANGE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // signed registers read back sign-extended
   always_comb begin
      case (reg_sel)
         REG_TARGET_LINE: begin
            csr_prdata = cfg_ff.target_line;
         end
         REG_CRUISE_SPEED: begin
            csr_prdata = cfg_ff.cruise_speed;
         end
         REG_PROP_GAIN: begin
            csr_prdata = {{(CSR_DATA_WIDTH-GAIN_WIDTH){cfg_ff.prop_gain[GAIN_WIDTH-1]}},
                          cfg_ff.prop_gain};
         end
         REG_INTEGRAL_GAIN: begin
            csr_prdata = {{(CSR_DATA_WIDTH-GAIN_WIDTH){cfg_ff.integral_gain[GAIN_WIDTH-1]}},
                          cfg_ff.integral_gain};
         end
         REG_DERIVATIVE_GAIN: begin
            csr_prdata = {{(CSR_DATA_WIDTH-GAIN_WIDTH){cfg_ff.derivative_gain[GAIN_WIDTH-1]}},
                          cfg_ff.derivative_gain};
         end
         REG_STOP_RANGE: begin
            csr_prdata = {{(CSR_DATA_WIDTH-RANGE_WIDTH){1'b0}}, cfg_ff.stop_range};
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ rtl/line_follow_pid_with_obstacle_stop.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Line-following PID steering with a sticky obstacle stop. Every input word is
// taken into an input register, one per clock; range samples and pose updates
// are consumed there and produce nothing on the result side. A control tick
// leaves the input register, computes the error, updates the loop state
// (saturating integral of SUM_WIDTH bits, previous error) in that same cycle
// unless stopped, has its three gain products formed in the next stage and is
// rounded and saturated into the output register. The sustained rate is one
// word per clock in any mix; input ready drops only while a tick waits behind
// a full pipeline held by result backpressure. Once a range sample below
// stop_range is seen, each tick returns zero commands with error_valid low and
// blocked high, until reset. Registers are written through the APB-style port
// by the user only while the block is idle; the block does not enforce this.

module line_follow_pid_with_obstacle_stop import lfpid_pkg::*; #(
   parameter int SUM_WIDTH = 48
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // req_tdata: range_sample[15:0], lateral_pos[47:16]
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [47:0]               req_tdata,
   // req_tuser: mode[1:0]
   input  wire logic [1:0]                req_tuser,
   // rsp_tdata: track_error[31:0], forward_cmd[63:32], turn_cmd[95:64]
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [95:0]                    rsp_tdata,
   // rsp_tuser: error_valid[0], blocked[1]
   output logic [1:0]                     rsp_tuser,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                           csr_pready
);

`include "line_follow_pid_with_obstacle_stop_assert.svh"

   localparam int DIFF_WIDTH   = DATA_WIDTH + 1;
   localparam int PROD_P_WIDTH = DATA_WIDTH + GAIN_WIDTH;
   localparam int PROD_D_WIDTH = DIFF_WIDTH + GAIN_WIDTH;
   localparam int PROD_I_WIDTH = SUM_WIDTH + GAIN_WIDTH;
   localparam int TURN_WIDTH   = SUM_WIDTH + GAIN_WIDTH + 2;
   localparam int QUOT_WIDTH   = TURN_WIDTH - FRAC_BITS;
   localparam logic signed [TURN_WIDTH-1:0] ROUND_HALF =
      TURN_WIDTH'(1) <<< (FRAC_BITS - 1);

   cfg_type cfg;

   lfpid_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // handshake
   logic s0_valid_ff, s0_valid_in;
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic out_valid_ff, out_valid_in;
   logic s0_tick, s0_adv, s1_adv, s2_adv;
   logic s1_free, s2_free, out_free, req_take;

   // input register
   logic [MODE_WIDTH-1:0]        s0_mode_ff, s0_mode_in;
   logic [RANGE_WIDTH-1:0]       s0_range_ff, s0_range_in;
   logic signed [DATA_WIDTH-1:0] s0_pos_ff, s0_pos_in;

   // loop state
   logic                         obstacle_ff, obstacle_in;
   logic signed [DATA_WIDTH-1:0] last_pos_ff, last_pos_in;
   logic signed [SUM_WIDTH-1:0]  sum_ff, sum_in;
   logic signed [DATA_WIDTH-1:0] prev_ff, prev_in;

   // stage 1
   logic                         s1_stop_ff, s1_stop_in;
   logic signed [DATA_WIDTH-1:0] s1_err_ff, s1_err_in;
   logic signed [SUM_WIDTH-1:0]  s1_sum_ff, s1_sum_in;
   logic signed [DIFF_WIDTH-1:0] s1_diff_ff, s1_diff_in;

   // stage 2
   logic                           s2_stop_ff, s2_stop_in;
   logic signed [DATA_WIDTH-1:0]   s2_err_ff, s2_err_in;
   logic signed [PROD_P_WIDTH-1:0] s2_pp_ff, s2_pp_in;
   logic signed [PROD_I_WIDTH-1:0] s2_pi_ff, s2_pi_in;
   logic signed [PROD_D_WIDTH-1:0] s2_pd_ff, s2_pd_in;

   // output register
   logic                         out_stop_ff, out_stop_in;
   logic signed [DATA_WIDTH-1:0] out_err_ff, out_err_in;
   logic signed [DATA_WIDTH-1:0] out_fwd_ff, out_fwd_in;
   logic signed [DATA_WIDTH-1:0] out_turn_ff, out_turn_in;

   // datapath nets
   logic [DIFF_WIDTH-1:0]       err_full;
   logic signed [DATA_WIDTH-1:0] err_sat;
   logic [SUM_WIDTH:0]          sum_wide;
   logic signed [SUM_WIDTH-1:0] sum_sat;
   logic signed [TURN_WIDTH-1:0] turn_full;
   logic signed [TURN_WIDTH-1:0] turn_rnd;
   logic [QUOT_WIDTH-1:0]       turn_quot;
   logic signed [DATA_WIDTH-1:0] turn_sat;
   logic                        quot_fits;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign s2_free    = !s2_valid_ff || out_free;
   assign s1_free    = !s1_valid_ff || s2_free;
   assign s2_adv     = s2_valid_ff && out_free;
   assign s1_adv     = s1_valid_ff && s2_free;
   assign s0_tick    = s0_valid_ff && (s0_mode_ff == MODE_TICK);
   assign s0_adv     = s0_valid_ff && (!s0_tick || s1_free);
   assign req_tready = !s0_valid_ff || s0_adv;
   assign req_take   = req_tvalid && req_tready;

   // error and saturating integral
   assign err_full = {cfg.target_line[DATA_WIDTH-1], cfg.target_line}
                   - {last_pos_ff[DATA_WIDTH-1], last_pos_ff};

   always_comb begin
      if (err_full[DIFF_WIDTH-1] != err_full[DATA_WIDTH-1]) begin
         err_sat = {err_full[DIFF_WIDTH-1], {(DATA_WIDTH-1){~err_full[DIFF_WIDTH-1]}}};
      end else begin
         err_sat = err_full[DATA_WIDTH-1:0];
      end
   end

   assign sum_wide = {sum_ff[SUM_WIDTH-1], sum_ff}
                   + {{(SUM_WIDTH+1-DATA_WIDTH){err_sat[DATA_WIDTH-1]}}, err_sat};

   always_comb begin
      if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
         sum_sat = {sum_wide[SUM_WIDTH], {(SUM_WIDTH-1){~sum_wide[SUM_WIDTH]}}};
      end else begin
         sum_sat = sum_wide[SUM_WIDTH-1:0];
      end
   end

   always_comb begin
      s0_valid_in = s0_valid_ff;
      s0_mode_in  = s0_mode_ff;
      s0_range_in = s0_range_ff;
      s0_pos_in   = s0_pos_ff;
      if (s0_adv) begin
         s0_valid_in = 1'b0;
      end
      if (req_take) begin
         s0_valid_in = 1'b1;
         s0_mode_in  = req_tuser;
         s0_range_in = req_tdata[RANGE_WIDTH-1:0];
         s0_pos_in   = req_tdata[RANGE_WIDTH +: DATA_WIDTH];
      end
   end

   always_comb begin
      obstacle_in = obstacle_ff;
      last_pos_in = last_pos_ff;
      sum_in      = sum_ff;
      prev_in     = prev_ff;
      s1_stop_in  = s1_stop_ff;
      s1_err_in   = s1_err_ff;
      s1_sum_in   = s1_sum_ff;
      s1_diff_in  = s1_diff_ff;
      if (s0_adv) begin
         case (s0_mode_ff)
            MODE_RANGE: begin
               if (s0_range_ff < cfg.stop_range) begin
                  obstacle_in = 1'b1;
               end
            end
            MODE_POSE: begin
               last_pos_in = s0_pos_ff;
            end
            MODE_TICK: begin
               s1_stop_in = obstacle_ff;
               s1_err_in  = err_sat;
               s1_sum_in  = sum_sat;
               s1_diff_in = {err_sat[DATA_WIDTH-1], err_sat} - {prev_ff[DATA_WIDTH-1], prev_ff};
               if (!obstacle_ff) begin
                  sum_in  = sum_sat;
                  prev_in = err_sat;
               end
            end
            default: begin
               obstacle_in = obstacle_ff;
            end
         endcase
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      if (s0_adv && s0_tick) begin
         s1_valid_in = 1'b1;
      end
   end

   // gain products
   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_stop_in  = s2_stop_ff;
      s2_err_in   = s2_err_ff;
      s2_pp_in    = s2_pp_ff;
      s2_pi_in    = s2_pi_ff;
      s2_pd_in    = s2_pd_ff;
      if (s2_adv) begin
         s2_valid_in = 1'b0;
      end
      if (s1_adv) begin
         s2_valid_in = 1'b1;
         s2_stop_in  = s1_stop_ff;
         s2_err_in   = s1_err_ff;
         s2_pp_in    = $signed(cfg.prop_gain) * s1_err_ff;
         s2_pi_in    = $signed(cfg.integral_gain) * s1_sum_ff;
         s2_pd_in    = $signed(cfg.derivative_gain) * s1_diff_ff;
      end
   end

   // sum, round half up, saturate
   assign turn_full =
        {{(TURN_WIDTH-PROD_P_WIDTH){s2_pp_ff[PROD_P_WIDTH-1]}}, s2_pp_ff}
      + {{(TURN_WIDTH-PROD_I_WIDTH){s2_pi_ff[PROD_I_WIDTH-1]}}, s2_pi_ff}
      + {{(TURN_WIDTH-PROD_D_WIDTH){s2_pd_ff[PROD_D_WIDTH-1]}}, s2_pd_ff};
   assign turn_rnd  = turn_full + ROUND_HALF;
   assign turn_quot = turn_rnd[TURN_WIDTH-1:FRAC_BITS];
   assign quot_fits = (&turn_quot[QUOT_WIDTH-1:DATA_WIDTH-1])
                   || !(|turn_quot[QUOT_WIDTH-1:DATA_WIDTH-1]);

   always_comb begin
      if (quot_fits) begin
         turn_sat = turn_quot[DATA_WIDTH-1:0];
      end else begin
         turn_sat = {turn_quot[QUOT_WIDTH-1], {(DATA_WIDTH-1){~turn_quot[QUOT_WIDTH-1]}}};
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_stop_in  = out_stop_ff;
      out_err_in   = out_err_ff;
      out_fwd_in   = out_fwd_ff;
      out_turn_in  = out_turn_ff;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (s2_adv) begin
         out_valid_in = 1'b1;
         out_stop_in  = s2_stop_ff;
         out_err_in   = s2_stop_ff ? '0 : s2_err_ff;
         out_fwd_in   = s2_stop_ff ? '0 : cfg.cruise_speed;
         out_turn_in  = s2_stop_ff ? '0 : turn_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         obstacle_ff  <= 1'b0;
         last_pos_ff  <= '0;
         sum_ff       <= '0;
         prev_ff      <= '0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
         obstacle_ff  <= obstacle_in;
         last_pos_ff  <= last_pos_in;
         sum_ff       <= sum_in;
         prev_ff      <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      s0_mode_ff  <= s0_mode_in;
      s0_range_ff <= s0_range_in;
      s0_pos_ff   <= s0_pos_in;
      s1_stop_ff  <= s1_stop_in;
      s1_err_ff   <= s1_err_in;
      s1_sum_ff   <= s1_sum_in;
      s1_diff_ff  <= s1_diff_in;
      s2_stop_ff  <= s2_stop_in;
      s2_err_ff   <= s2_err_in;
      s2_pp_ff    <= s2_pp_in;
      s2_pi_ff    <= s2_pi_in;
      s2_pd_ff    <= s2_pd_in;
      out_stop_ff <= out_stop_in;
      out_err_ff  <= out_err_in;
      out_fwd_ff  <= out_fwd_in;
      out_turn_ff <= out_turn_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_turn_ff, out_fwd_ff, out_err_ff};
   assign rsp_tuser  = {out_stop_ff, ~out_stop_ff};

   `LFPID_ASSERT_NEXT(a_obstacle_sticky, clock, reset, obstacle_ff, obstacle_ff)
   `LFPID_ASSERT_NEXT(a_stopped_tick_holds_loop, clock, reset,
                      s0_adv && s0_tick && obstacle_ff, $stable(sum_ff) && $stable(prev_ff))
   `LFPID_ASSERT_NOW(a_stall_only_on_tick, clock, reset, !req_tready, s0_tick && !s1_free)
   `LFPID_ASSERT_NEXT(a_stage1_kept_when_blocked, clock, reset,
                      s1_valid_ff && !s2_free, s1_valid_ff)

endmodule

`default_nettype wire
